@@ sv/jvs_pkg.sv @@
`default_nettype none
package jvs_pkg;

    localparam int AXIS_W  = 12;
    localparam int VEL_W   = 16;
    localparam int MAG_W   = 15;
    localparam int SPEED_W = 15;
    localparam int ACT_W   = 11;
    localparam int ALPHA_W = 9;
    localparam int NUM_W   = 54;
    localparam int SUM_W   = 24;
    localparam int DEN_W   = 23;
    localparam int CNT_W   = 6;

    localparam logic [CNT_W-1:0] MUL_STEPS  = CNT_W'(SUM_W - 1);
    localparam logic [CNT_W-1:0] DIV_STEPS  = CNT_W'(NUM_W - 1);
    localparam logic [CNT_W-1:0] SQRT_STEPS = CNT_W'(NUM_W / 2 - 1);

    localparam logic [2:0] REG_DEAD_ZONE  = 3'd0;
    localparam logic [2:0] REG_FULL_SCALE = 3'd1;
    localparam logic [2:0] REG_MAX_LIN    = 3'd2;
    localparam logic [2:0] REG_MAX_ANG    = 3'd3;
    localparam logic [2:0] REG_LIN_ALPHA  = 3'd4;
    localparam logic [2:0] REG_ANG_ALPHA  = 3'd5;
    localparam logic [2:0] REG_THRESHOLD  = 3'd6;
    localparam logic [2:0] REG_ZERO_BAND  = 3'd7;

    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_CMD    = 1'b1;

    localparam logic [1:0] CH_X   = 2'd0;
    localparam logic [1:0] CH_Y   = 2'd1;
    localparam logic [1:0] CH_ANG = 2'd2;

    typedef struct packed {
        logic              req_type;
        logic [AXIS_W-1:0] axis_0;
        logic [AXIS_W-1:0] axis_1;
        logic [AXIS_W-1:0] axis_2;
        logic [AXIS_W-1:0] axis_3;
        logic [15:0]       buttons;
        logic              cmd_enable;
        logic              cmd_aim;
    } t_in_item;

    typedef struct packed {
        logic [VEL_W-1:0] vel_x;
        logic [VEL_W-1:0] vel_y;
        logic [VEL_W-1:0] vel_ang;
        logic             aim_active;
        logic             is_ack;
    } t_out_item;

    typedef struct packed {
        logic [SPEED_W-1:0] speed;
        logic [AXIS_W-1:0]  ua;
        logic [AXIS_W-1:0]  ub;
        logic [ACT_W-1:0]   full_scale;
    } t_mag_req;

    typedef enum logic [2:0] {
        M_IDLE, M_SQ, M_MUL, M_DIV, M_SQRT, M_DONE
    } t_mag_state;

    typedef enum logic [2:0] {
        S_IDLE, S_MAG, S_WAIT, S_SMOOTH, S_OUT
    } t_state;

endpackage
`default_nettype wire

@@ sv/jvs_mag.sv @@
`default_nettype none
module jvs_mag (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire jvs_pkg::t_mag_req i_req,
    output logic                   o_done,
    output logic [jvs_pkg::MAG_W-1:0] o_mag
);

    jvs_pkg::t_mag_state r_state, n_state;

    logic [jvs_pkg::CNT_W-1:0]   r_cnt;
    logic [2*jvs_pkg::SPEED_W-1:0] r_sp2;
    logic [jvs_pkg::SUM_W-1:0]   r_sum;
    logic [jvs_pkg::DEN_W-1:0]   r_den;
    logic [jvs_pkg::NUM_W-1:0]   r_acc;
    logic [jvs_pkg::DEN_W-1:0]   r_rem;
    logic [jvs_pkg::NUM_W-1:0]   r_r;
    logic [jvs_pkg::NUM_W-1:0]   r_bit;
    jvs_pkg::t_mag_req           r_req;

    logic [jvs_pkg::ACT_W-1:0]   ma;
    logic [jvs_pkg::DEN_W:0]     div_t;
    logic [jvs_pkg::NUM_W-1:0]   sq_t;
    logic [jvs_pkg::NUM_W-1:0]   mul_add;
    logic                        div_ge;
    logic                        sq_ge;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= jvs_pkg::M_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_done  = 1'b0;
        case (r_state)
            jvs_pkg::M_IDLE: begin
                if (i_start) n_state = jvs_pkg::M_SQ;
            end
            jvs_pkg::M_SQ:   n_state = jvs_pkg::M_MUL;
            jvs_pkg::M_MUL: begin
                if (r_cnt == '0) n_state = jvs_pkg::M_DIV;
            end
            jvs_pkg::M_DIV: begin
                if (r_cnt == '0) n_state = jvs_pkg::M_SQRT;
            end
            jvs_pkg::M_SQRT: begin
                if (r_cnt == '0) n_state = jvs_pkg::M_DONE;
            end
            jvs_pkg::M_DONE: begin
                o_done  = 1'b1;
                n_state = jvs_pkg::M_IDLE;
            end
            default: n_state = jvs_pkg::M_IDLE;
        endcase
    end

    assign ma      = (r_req.full_scale == '0) ? jvs_pkg::ACT_W'(1) : r_req.full_scale;
    assign mul_add = r_sum[r_cnt[4:0]] ? jvs_pkg::NUM_W'(r_sp2) : '0;
    assign div_t   = {r_rem, r_acc[jvs_pkg::NUM_W-1]};
    assign div_ge  = div_t >= {1'b0, r_den};
    assign sq_t    = r_r + r_bit;
    assign sq_ge   = r_acc >= sq_t;

    always_ff @(posedge i_clk) begin
        case (r_state)
            jvs_pkg::M_IDLE: begin
                if (i_start) r_req <= i_req;
            end
            jvs_pkg::M_SQ: begin
                r_sp2 <= r_req.speed * r_req.speed;
                r_sum <= jvs_pkg::SUM_W'(r_req.ua * r_req.ua)
                       + jvs_pkg::SUM_W'(r_req.ub * r_req.ub);
                r_den <= (jvs_pkg::DEN_W'(ma) * jvs_pkg::DEN_W'(ma)) << 1;
                r_acc <= '0;
                r_cnt <= jvs_pkg::MUL_STEPS;
            end
            jvs_pkg::M_MUL: begin
                r_acc <= {r_acc[jvs_pkg::NUM_W-2:0], 1'b0} + mul_add;
                r_cnt <= (r_cnt == '0) ? jvs_pkg::DIV_STEPS : r_cnt - 1'b1;
                r_rem <= '0;
            end
            jvs_pkg::M_DIV: begin
                r_rem <= div_ge ? jvs_pkg::DEN_W'(div_t - {1'b0, r_den})
                                : div_t[jvs_pkg::DEN_W-1:0];
                r_acc <= {r_acc[jvs_pkg::NUM_W-2:0], div_ge};
                r_cnt <= (r_cnt == '0) ? jvs_pkg::SQRT_STEPS : r_cnt - 1'b1;
                r_r   <= '0;
                r_bit <= jvs_pkg::NUM_W'(1) << (jvs_pkg::NUM_W - 2);
            end
            jvs_pkg::M_SQRT: begin
                if (sq_ge) begin
                    r_acc <= r_acc - sq_t;
                    r_r   <= (r_r >> 1) + r_bit;
                end else begin
                    r_r   <= r_r >> 1;
                end
                r_bit <= r_bit >> 2;
                r_cnt <= r_cnt - 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign o_mag = (r_r > jvs_pkg::NUM_W'(32767)) ? jvs_pkg::MAG_W'(32767)
                                                  : r_r[jvs_pkg::MAG_W-1:0];

    a_done_after_sqrt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_state) == jvs_pkg::M_SQRT)
        else $error("magnitude done without root pass");
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == jvs_pkg::M_SQ) |-> $past(i_start))
        else $error("magnitude run without start");
    a_div_follows_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == jvs_pkg::M_DIV && $past(r_state) != jvs_pkg::M_DIV)
        |-> $past(r_state) == jvs_pkg::M_MUL)
        else $error("divide entered out of order");

endmodule
`default_nettype wire

@@ sv/joystick_velocity_shaper_unit.sv @@
// joystick velocity shaper
// input channel: i_in_valid / o_in_stall carry a sample or a mode command
// (req_type). output channel: o_out_valid / i_out_stall carry one result.
// a transfer happens at a rising edge with valid high and stall low.
// a mode command's acknowledge goes from S_OUT into the output register once free.
// a sample runs each of its two (aim mode) or three (otherwise) speed
// magnitudes through one shared multiply / divide / square-root unit
// (start, squaring, 24 multiply steps, 54 divide steps, 27 root steps,
// done, smoothing); its result then enters the output register once
// that is free, and the block returns to idle to take the next input.
// a sample while disabled gives no result and the block is free next cycle.
// one item is worked on at a time; o_in_stall is high while it is busy.
// a finished result waits in the output register while i_out_stall is
// high, and a next item may be taken meanwhile.
// reset restores the configuration registers to their defaults, enables processing,
// clears aim mode, button history and smoother memory.
// apb port: registers at byte address 4*index, pready always high.
`default_nettype none
module joystick_velocity_shaper_unit #(
    parameter int AIM_BUTTON_BIT = 10
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    input  wire jvs_pkg::t_in_item  i_in_data,
    output logic                    o_in_stall,
    output logic                    o_out_valid,
    output jvs_pkg::t_out_item      o_out_data,
    input  wire logic               i_out_stall,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [4:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    localparam int AW = jvs_pkg::AXIS_W;
    localparam int VW = jvs_pkg::VEL_W;

    logic [10:0] r_dead_zone;
    logic [10:0] r_full_scale;
    logic [14:0] r_max_lin;
    logic [14:0] r_max_ang;
    logic [8:0]  r_lin_alpha;
    logic [8:0]  r_ang_alpha;
    logic [14:0] r_threshold;
    logic [14:0] r_zero_band;

    jvs_pkg::t_state r_state, n_state;
    logic [15:0]         r_prev_buttons;
    logic                r_aim;
    logic                r_enabled;
    logic signed [VW-1:0] r_last_x, r_last_y, r_last_ang;
    logic signed [AW-1:0] r_a0, r_a1, r_a2, r_a3;
    logic [1:0]          r_ch;
    logic signed [VW-1:0] r_target;
    jvs_pkg::t_out_item  r_res;
    logic                r_out_valid;
    jvs_pkg::t_out_item  r_out_data;

    logic                cfg_wr;
    logic                in_xfer;
    logic                out_load;
    logic                mag_start;
    logic                mag_done;
    logic [jvs_pkg::MAG_W-1:0] mag;
    jvs_pkg::t_mag_req   mag_req;
    logic                aim_rise;

    logic signed [AW-1:0] d0, d1, d2, d3;
    logic signed [VW-1:0] sm_prev;
    logic [8:0]           sm_alpha_raw;
    logic [8:0]           sm_alpha;
    logic signed [VW:0]   sm_diff;
    logic [VW:0]          sm_adiff;
    logic signed [26:0]   sm_sum;
    logic signed [VW-1:0] sm_avg;
    logic signed [VW-1:0] sm_pre;
    logic [VW:0]          sm_amag;
    logic signed [VW-1:0] sm_out;
    logic signed [VW-1:0] tgt;
    logic                 tgt_neg;

    function automatic logic [AW-1:0] abs_axis(input logic signed [AW-1:0] a);
        abs_axis = a[AW-1] ? AW'(-a) : AW'(a);
    endfunction

    function automatic logic signed [AW-1:0] dead(input logic signed [AW-1:0] a,
                                                  input logic [10:0] dz);
        dead = ({1'b0, abs_axis(a)} < 13'(dz)) ? '0 : a;
    endfunction

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dead_zone  <= 11'd10;
            r_full_scale <= 11'd664;
            r_max_lin    <= 15'd16384;
            r_max_ang    <= 15'd24576;
            r_lin_alpha  <= 9'd77;
            r_ang_alpha  <= 9'd51;
            r_threshold  <= 15'd3277;
            r_zero_band  <= 15'd41;
        end else if (cfg_wr) begin
            case (paddr[4:2])
                jvs_pkg::REG_DEAD_ZONE:  r_dead_zone  <= pwdata[10:0];
                jvs_pkg::REG_FULL_SCALE: r_full_scale <= pwdata[10:0];
                jvs_pkg::REG_MAX_LIN:    r_max_lin    <= pwdata[14:0];
                jvs_pkg::REG_MAX_ANG:    r_max_ang    <= pwdata[14:0];
                jvs_pkg::REG_LIN_ALPHA:  r_lin_alpha  <= pwdata[8:0];
                jvs_pkg::REG_ANG_ALPHA:  r_ang_alpha  <= pwdata[8:0];
                jvs_pkg::REG_THRESHOLD:  r_threshold  <= pwdata[14:0];
                jvs_pkg::REG_ZERO_BAND:  r_zero_band  <= pwdata[14:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            jvs_pkg::REG_DEAD_ZONE:  prdata = 32'(r_dead_zone);
            jvs_pkg::REG_FULL_SCALE: prdata = 32'(r_full_scale);
            jvs_pkg::REG_MAX_LIN:    prdata = 32'(r_max_lin);
            jvs_pkg::REG_MAX_ANG:    prdata = 32'(r_max_ang);
            jvs_pkg::REG_LIN_ALPHA:  prdata = 32'(r_lin_alpha);
            jvs_pkg::REG_ANG_ALPHA:  prdata = 32'(r_ang_alpha);
            jvs_pkg::REG_THRESHOLD:  prdata = 32'(r_threshold);
            jvs_pkg::REG_ZERO_BAND:  prdata = 32'(r_zero_band);
            default:                 prdata = '0;
        endcase
    end

    assign o_in_stall  = (r_state != jvs_pkg::S_IDLE);
    assign in_xfer     = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign aim_rise    = i_in_data.buttons[AIM_BUTTON_BIT]
                      && !r_prev_buttons[AIM_BUTTON_BIT];

    assign d0 = dead(i_in_data.axis_0, r_dead_zone);
    assign d1 = dead(i_in_data.axis_1, r_dead_zone);
    assign d2 = dead(i_in_data.axis_2, r_dead_zone);
    assign d3 = dead(i_in_data.axis_3, r_dead_zone);

    always_comb begin
        case (r_ch)
            jvs_pkg::CH_X: begin
                mag_req = '{speed: r_max_lin, ua: abs_axis(r_a1), ub: '0,
                            full_scale: r_full_scale};
                tgt_neg = r_a1[AW-1];
                sm_prev = r_last_x;
                sm_alpha_raw = r_lin_alpha;
            end
            jvs_pkg::CH_Y: begin
                mag_req = '{speed: r_max_lin, ua: abs_axis(r_a0), ub: '0,
                            full_scale: r_full_scale};
                tgt_neg = r_a0[AW-1];
                sm_prev = r_last_y;
                sm_alpha_raw = r_lin_alpha;
            end
            default: begin
                mag_req = '{speed: r_max_ang, ua: abs_axis(r_a2),
                            ub: abs_axis(r_a3), full_scale: r_full_scale};
                tgt_neg = !r_a2[AW-1] && (r_a2 != '0);
                sm_prev = r_last_ang;
                sm_alpha_raw = r_ang_alpha;
            end
        endcase
    end

    assign tgt = tgt_neg ? -VW'(mag) : VW'(mag);

    assign sm_alpha = (sm_alpha_raw > 9'd256) ? 9'd256 : sm_alpha_raw;
    assign sm_diff  = 17'(r_target) - 17'(sm_prev);
    assign sm_adiff = sm_diff[VW] ? 17'(-sm_diff) : 17'(sm_diff);
    assign sm_sum   = 27'($signed({1'b0, sm_alpha}) * r_target)
                    + 27'($signed({1'b0, 9'd256 - sm_alpha}) * sm_prev)
                    + 27'sd128;
    assign sm_avg   = sm_sum[23:8];
    assign sm_pre   = (sm_adiff < 17'(r_threshold)) ? sm_avg : r_target;
    assign sm_amag  = sm_pre[VW-1] ? 17'(-17'(sm_pre)) : 17'(sm_pre);
    assign sm_out   = (sm_amag < 17'(r_zero_band)) ? '0 : sm_pre;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= jvs_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        mag_start = 1'b0;
        out_load  = 1'b0;
        case (r_state)
            jvs_pkg::S_IDLE: begin
                if (in_xfer) begin
                    if (i_in_data.req_type == jvs_pkg::REQ_CMD) begin
                        n_state = jvs_pkg::S_OUT;
                    end else if (r_enabled) begin
                        n_state = jvs_pkg::S_MAG;
                    end
                end
            end
            jvs_pkg::S_MAG: begin
                mag_start = 1'b1;
                n_state   = jvs_pkg::S_WAIT;
            end
            jvs_pkg::S_WAIT: begin
                if (mag_done) n_state = jvs_pkg::S_SMOOTH;
            end
            jvs_pkg::S_SMOOTH: begin
                if (r_ch == jvs_pkg::CH_X) begin
                    n_state = jvs_pkg::S_MAG;
                end else if (r_ch == jvs_pkg::CH_Y && !r_aim) begin
                    n_state = jvs_pkg::S_MAG;
                end else begin
                    n_state = jvs_pkg::S_OUT;
                end
            end
            jvs_pkg::S_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    out_load = 1'b1;
                    n_state  = jvs_pkg::S_IDLE;
                end
            end
            default: n_state = jvs_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_buttons <= '0;
            r_aim          <= 1'b0;
            r_enabled      <= 1'b1;
            r_last_x       <= '0;
            r_last_y       <= '0;
            r_last_ang     <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == jvs_pkg::S_IDLE && in_xfer) begin
                if (i_in_data.req_type == jvs_pkg::REQ_CMD) begin
                    r_enabled <= i_in_data.cmd_enable;
                    r_aim     <= i_in_data.cmd_aim;
                end else if (r_enabled) begin
                    r_prev_buttons <= i_in_data.buttons;
                    if (aim_rise) r_aim <= !r_aim;
                end
            end
            if (r_state == jvs_pkg::S_SMOOTH) begin
                case (r_ch)
                    jvs_pkg::CH_X: r_last_x   <= sm_out;
                    jvs_pkg::CH_Y: r_last_y   <= sm_out;
                    default:       r_last_ang <= sm_out;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) r_out_data <= r_res;
        case (r_state)
            jvs_pkg::S_IDLE: begin
                r_a0 <= d0;
                r_a1 <= d1;
                r_a2 <= d2;
                r_a3 <= d3;
                r_ch <= jvs_pkg::CH_X;
                r_res.vel_x   <= '0;
                r_res.vel_y   <= '0;
                r_res.vel_ang <= '0;
                r_res.is_ack  <= (i_in_data.req_type == jvs_pkg::REQ_CMD);
                if (i_in_data.req_type == jvs_pkg::REQ_CMD) begin
                    r_res.aim_active <= i_in_data.cmd_aim;
                end else begin
                    r_res.aim_active <= r_aim ^ aim_rise;
                end
            end
            jvs_pkg::S_WAIT: begin
                if (mag_done) r_target <= tgt;
            end
            jvs_pkg::S_SMOOTH: begin
                r_ch <= r_ch + 2'd1;
                case (r_ch)
                    jvs_pkg::CH_X: r_res.vel_x   <= sm_out;
                    jvs_pkg::CH_Y: r_res.vel_y   <= sm_out;
                    default:       r_res.vel_ang <= sm_out;
                endcase
            end
            default: begin
            end
        endcase
    end

    jvs_mag u_mag (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mag_start),
        .i_req   (mag_req),
        .o_done  (mag_done),
        .o_mag   (mag)
    );

    a_busy_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != jvs_pkg::S_IDLE) |-> o_in_stall)
        else $error("input taken while busy");
    a_ack_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.is_ack) |->
        (o_out_data.vel_x == '0 && o_out_data.vel_y == '0 && o_out_data.vel_ang == '0))
        else $error("acknowledge carries velocity");
    a_aim_no_ang: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.aim_active) |-> o_out_data.vel_ang == '0)
        else $error("angular output in aim mode");
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> (!r_out_valid || !i_out_stall))
        else $error("result overwritten while held");

endmodule
`default_nettype wire
